[rtl/cgts_pkg.sv]
// Shared types and constants for the cuckoo granule tag store.
package cgts_pkg;

  localparam logic [1:0] KIND_CHECK = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [3:0] SHIFT_MAX   = 4'd12;
  localparam logic [3:0] SHIFT_RESET = 4'd4;

  localparam logic [31:0] SALT_MUL_A = 32'h7a5b149e;
  localparam logic [63:0] HASH_MUL_A = 64'h9e3779b97f4a7c15;
  localparam logic [31:0] SALT_MUL_B = 32'ha6b21179;
  localparam logic [63:0] HASH_MUL_B = 64'h6c62272e07bb0142;

  localparam logic [0:0] REG_SHIFT = 1'b0;
  localparam logic [0:0] REG_SALT  = 1'b1;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DP_NONE   = 4'd0,
    DP_LOAD   = 4'd1,  // capture the op and align the key
    DP_HASH   = 4'd2,  // not decoded; the hash pipeline runs freely on the key in hand
    DP_READ   = 4'd3,  // issue reads at both hashed rows
    DP_WR_SET = 4'd4,  // overwrite tag of matching slot
    DP_WR_CLR = 4'd5,  // invalidate matching slot
    DP_KICK_A = 4'd6,  // swap hand into first table
    DP_KICK_B = 4'd7,  // swap hand into second table
    DP_CLEAR  = 4'd8,  // clearing pass write
    DP_DONE   = 4'd9   // present the result
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    use_b;    // load the result beat from the hand (spill)
  } dp_ctrl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit_a;
    logic       hit_b;
    logic       free_a;
    logic       free_b;
    logic       clr_last;
  } dp_stat_t;

endpackage

[rtl/cuckoo_granule_tag_store.sv]
// Top level: cuckoo-hashed granule tag store with APB configuration.
// A set that misses both tables walks the eviction path for at most MaxKicks
//   rounds and spills the hand if no round frees a slot.
// Throughput: one operation at a time; busy drops in the strobe cycle.
// Each hash runs a key stage and a partial-product stage ahead of the table read.
// After reset a clearing pass over every row empties both tables,
//   with busy high; configuration resets to granule_shift 4, hash_salt 0.
module cuckoo_granule_tag_store #(
  parameter int IndexBits = 10,
  parameter int MaxKicks  = 32,
  parameter int AddrBits  = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                strobe_o,
  input  logic [1:0]          kind_i,
  input  logic [AddrBits-1:0] address_i,
  input  logic [7:0]          tag_i,
  output logic                tag_match_o,
  output logic                found_o,
  output logic                ok_o,
  output logic [AddrBits-1:0] spill_address_o,
  output logic [7:0]          spill_tag_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cgts_pkg::*;

  logic [3:0] shift_q;
  logic [7:0] salt_q;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
      salt_q  <= 8'd0;
    end else if (wr) begin
      if (paddr[2] == REG_SHIFT) begin
        shift_q <= (pwdata[3:0] > SHIFT_MAX) ? SHIFT_MAX : pwdata[3:0];
      end else begin
        salt_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {28'd0, shift_q};
    else if (paddr == 3'd4) prdata = {24'd0, salt_q};
  end

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  cgts_ctrl #(.MaxKicks(MaxKicks)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o(strobe_o),
    .ctrl_o(ctrl), .stat_i(stat)
  );

  cgts_datapath #(.IndexBits(IndexBits), .AddrBits(AddrBits)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .kind_i, .address_i, .tag_i, .shift_i(shift_q), .salt_i(salt_q),
    .tag_match_o, .found_o, .ok_o, .spill_address_o, .spill_tag_o
  );
endmodule

[rtl/cgts_ram.sv]
// Generic single-port RAM with registered read.
module cgts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/cgts_datapath.sv]
// Datapath: key alignment, hash pipeline, two tables and the hand register.
module cgts_datapath #(
  parameter int IndexBits = 10,
  parameter int AddrBits  = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cgts_pkg::dp_ctrl_t    ctrl_i,
  output cgts_pkg::dp_stat_t    stat_o,
  input  logic [1:0]            kind_i,
  input  logic [AddrBits-1:0]   address_i,
  input  logic [7:0]            tag_i,
  input  logic [3:0]            shift_i,
  input  logic [7:0]            salt_i,
  output logic                  tag_match_o,
  output logic                  found_o,
  output logic                  ok_o,
  output logic [AddrBits-1:0]   spill_address_o,
  output logic [7:0]            spill_tag_o
);
  import cgts_pkg::*;

  localparam int EntW = 1 + AddrBits + 8;

  logic [1:0]          kind_q;
  logic [7:0]          tag_q;
  logic [AddrBits-1:0] hand_addr_q;
  logic [7:0]          hand_tag_q;
  logic [63:0]         key_a_q, key_b_q;
  logic [63:0]         pa_a_q, pa_b_q;
  logic [31:0]         pb_a_q, pb_b_q, pc_a_q, pc_b_q;
  logic [31:0]         top_a, top_b;
  logic [39:0]         salt_a, salt_b;
  logic [IndexBits-1:0] idx_a_q, idx_b_q, clr_q;
  logic [EntW-1:0]     rd_a, rd_b, wd_a, wd_b;
  logic                we_a, we_b;
  logic [IndexBits-1:0] ad_a, ad_b;
  logic [AddrBits-1:0] base, gmask, gran;
  logic [63:0]         kbase;

  // Align down and build the unsalted key.
  always_comb begin
    base  = (kind_i == KIND_CHECK) ? address_i - AddrBits'(4) : address_i;
    gmask = ~((AddrBits'(1) << shift_i) - AddrBits'(1));
    gran  = base & gmask;
    kbase = 64'(hand_addr_q) >> shift_i;
    salt_a = 40'(salt_i) * 40'(SALT_MUL_A);
    salt_b = 40'(salt_i) * 40'(SALT_MUL_B);
    // Upper half of the 64-bit product from the registered partial products.
    top_a = pa_a_q[63:32] + pb_a_q + pc_a_q;
    top_b = pa_b_q[63:32] + pb_b_q + pc_b_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      DP_LOAD: begin
        kind_q      <= kind_i;
        tag_q       <= tag_i;
        hand_addr_q <= gran;
        hand_tag_q  <= tag_i;
      end
      DP_KICK_A: begin
        if (rd_a[EntW-1]) begin
          hand_addr_q <= rd_a[EntW-2 -: AddrBits];
          hand_tag_q  <= rd_a[7:0];
        end
      end
      DP_KICK_B: begin
        if (rd_b[EntW-1]) begin
          hand_addr_q <= rd_b[EntW-2 -: AddrBits];
          hand_tag_q  <= rd_b[7:0];
        end
      end
      default: ;
    endcase
    // Hash stages: salted key, then 32x32 partial products of the low 64 bits.
    key_a_q <= kbase ^ 64'(salt_a);
    key_b_q <= kbase ^ 64'(salt_b);
    pa_a_q  <= 64'(key_a_q[31:0]) * 64'(HASH_MUL_A[31:0]);
    pb_a_q  <= key_a_q[63:32] * HASH_MUL_A[31:0];
    pc_a_q  <= key_a_q[31:0] * HASH_MUL_A[63:32];
    pa_b_q  <= 64'(key_b_q[31:0]) * 64'(HASH_MUL_B[31:0]);
    pb_b_q  <= key_b_q[63:32] * HASH_MUL_B[31:0];
    pc_b_q  <= key_b_q[31:0] * HASH_MUL_B[63:32];
    if (ctrl_i.cmd == DP_READ) begin
      idx_a_q <= top_a[31 -: IndexBits];
      idx_b_q <= top_b[31 -: IndexBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.cmd == DP_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  logic hit_a, hit_b;
  assign hit_a = rd_a[EntW-1] && rd_a[EntW-2 -: AddrBits] == hand_addr_q;
  assign hit_b = rd_b[EntW-1] && rd_b[EntW-2 -: AddrBits] == hand_addr_q;

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    ad_a = (ctrl_i.cmd == DP_READ) ? top_a[31 -: IndexBits] : idx_a_q;
    ad_b = (ctrl_i.cmd == DP_READ) ? top_b[31 -: IndexBits] : idx_b_q;
    wd_a = {1'b1, hand_addr_q, hand_tag_q};
    wd_b = {1'b1, hand_addr_q, hand_tag_q};
    unique case (ctrl_i.cmd)
      DP_WR_SET: begin
        we_a = hit_a;
        we_b = !hit_a && hit_b;
        wd_a = {rd_a[EntW-1:8], tag_q};
        wd_b = {rd_b[EntW-1:8], tag_q};
      end
      DP_WR_CLR: begin
        we_a = hit_a;
        we_b = !hit_a && hit_b;
        wd_a = '0;
        wd_b = '0;
      end
      DP_KICK_A: we_a = 1'b1;
      DP_KICK_B: we_b = 1'b1;
      DP_CLEAR: begin
        we_a = 1'b1;
        we_b = 1'b1;
        ad_a = clr_q;
        ad_b = clr_q;
        wd_a = '0;
        wd_b = '0;
      end
      default: ;
    endcase
  end

  cgts_ram #(.Width(EntW), .Depth(2 ** IndexBits)) u_ram_a (
    .clk_i, .we_i(we_a), .addr_i(ad_a), .wdata_i(wd_a), .rdata_o(rd_a)
  );
  cgts_ram #(.Width(EntW), .Depth(2 ** IndexBits)) u_ram_b (
    .clk_i, .we_i(we_b), .addr_i(ad_b), .wdata_i(wd_b), .rdata_o(rd_b)
  );

  assign stat_o.kind     = kind_q;
  assign stat_o.hit_a    = hit_a;
  assign stat_o.hit_b    = hit_b;
  assign stat_o.free_a   = !rd_a[EntW-1];
  assign stat_o.free_b   = !rd_b[EntW-1];
  assign stat_o.clr_last = &clr_q;

  // Result register, loaded on the done command or, for a spill, from the hand.
  logic stored_match;
  assign stored_match = hit_a ? (rd_a[7:0] == tag_q) : (rd_b[7:0] == tag_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == DP_DONE) begin
      tag_match_o     <= (kind_q == KIND_CHECK) &&
                         ((hit_a || hit_b) ? stored_match : tag_q == 8'd0);
      found_o         <= (kind_q == KIND_CHECK || kind_q == KIND_SET ||
                          kind_q == KIND_CLEAR) && (hit_a || hit_b);
      ok_o            <= 1'b1;
      spill_address_o <= '0;
      spill_tag_o     <= '0;
    end else if (ctrl_i.use_b) begin
      // Walk exhausted: return the hand.
      tag_match_o     <= 1'b0;
      found_o         <= 1'b0;
      ok_o            <= 1'b0;
      spill_address_o <= hand_addr_q;
      spill_tag_o     <= hand_tag_q;
    end
  end
endmodule

[rtl/cgts_ctrl.sv]
// Controller: sequences the clearing pass, lookup, update and the eviction walk.
module cgts_ctrl #(
  parameter int MaxKicks = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output cgts_pkg::dp_ctrl_t ctrl_o,
  input  cgts_pkg::dp_stat_t stat_i
);
  import cgts_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_H1    = 12'b000000000100,
    S_H2    = 12'b000000001000,
    S_RD    = 12'b000000010000,
    S_LOOK  = 12'b000000100000,
    S_KA    = 12'b000001000000,
    S_HB1   = 12'b000010000000,
    S_HB2   = 12'b000100000000,
    S_RDB   = 12'b001000000000,
    S_KB    = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  localparam int KW = $clog2(MaxKicks + 1);

  state_e        state_q, state_d;
  logic [KW-1:0] kick_q, kick_d;
  logic          spill_q, spill_d;
  logic          first_q, first_d;

  always_comb begin
    state_d    = state_q;
    kick_d     = kick_q;
    spill_d    = spill_q;
    first_d    = first_q;
    ctrl_o.cmd   = DP_NONE;
    ctrl_o.use_b = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.cmd = DP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.cmd = DP_LOAD;
          kick_d     = '0;
          spill_d    = 1'b0;
          first_d    = 1'b1;
          state_d    = S_H1;
        end
      end
      S_H1: state_d = S_H2;
      S_H2: state_d = S_RD;
      S_RD: begin
        ctrl_o.cmd = DP_READ;
        state_d    = first_q ? S_LOOK : S_KA;
      end
      S_LOOK: begin
        first_d = 1'b0;
        if (stat_i.kind == KIND_SET && !stat_i.hit_a && !stat_i.hit_b) begin
          state_d = S_KA;
        end else begin
          if (stat_i.kind == KIND_SET) ctrl_o.cmd = DP_WR_SET;
          else if (stat_i.kind == KIND_CLEAR) ctrl_o.cmd = DP_WR_CLR;
          state_d = S_OUT;
        end
      end
      S_KA: begin
        ctrl_o.cmd = DP_KICK_A;
        state_d = stat_i.free_a ? S_OUT : S_HB1;
      end
      S_HB1: state_d = S_HB2;
      S_HB2: state_d = S_RDB;
      S_RDB: begin
        ctrl_o.cmd = DP_READ;
        state_d    = S_KB;
      end
      S_KB: begin
        ctrl_o.cmd = DP_KICK_B;
        kick_d     = kick_q + 1'b1;
        if (stat_i.free_b) begin
          state_d = S_OUT;
        end else if (kick_q == KW'(MaxKicks - 1)) begin
          spill_d = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_H1;
        end
      end
      S_OUT: begin
        // Spill loads result from the hand, otherwise the lookup outcome.
        if (spill_q) ctrl_o.use_b = 1'b1;
        else ctrl_o.cmd = DP_DONE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kick_q  <= '0;
      spill_q <= 1'b0;
      first_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      kick_q  <= kick_d;
      spill_q <= spill_d;
      first_q <= first_d;
      done_o  <= (state_q == S_OUT);
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_done_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> done_o) else $error("done missing");
  a_kick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick_q <= KW'(MaxKicks)) else $error("kick count overrun");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_H1) else $error("no start");
endmodule

[verif/testbench.sv]
// Self-checking testbench for the cuckoo granule tag store.
`timescale 1ns / 1ps

module testbench;
  import cgts_pkg::*;

  localparam int          IDX_BITS   = 10;
  localparam int          DEPTH      = 1 << IDX_BITS;
  localparam int          KICK_LIMIT = 32;
  localparam int          AW         = 48;
  localparam int          CYCLE_CAP  = 1500000;
  localparam logic [1:0]  KIND_NONE  = 2'd3;
  localparam logic [2:0]  ADDR_SHIFT = 3'd0;
  localparam logic [2:0]  ADDR_SALT  = 3'd4;

  typedef struct packed {
    logic          used;
    logic [AW-1:0] gaddr;
    logic [7:0]    tag;
  } entry_t;

  typedef struct packed {
    logic          tag_match;
    logic          found;
    logic          ok;
    logic [AW-1:0] spill_address;
    logic [7:0]    spill_tag;
  } verdict_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy, strobe_o;
  logic [1:0]    kind_i = KIND_CHECK;
  logic [AW-1:0] address_i = '0;
  logic [7:0]    tag_i = '0;
  logic          tag_match_o, found_o, ok_o;
  logic [AW-1:0] spill_address_o;
  logic [7:0]    spill_tag_o;
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  cuckoo_granule_tag_store #(
    .IndexBits(IDX_BITS), .MaxKicks(KICK_LIMIT), .AddrBits(AW)
  ) dut (
    .clk_i, .rst_ni, .start, .busy, .strobe_o, .kind_i, .address_i, .tag_i,
    .tag_match_o, .found_o, .ok_o, .spill_address_o, .spill_tag_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  entry_t        first_tbl[DEPTH];
  entry_t        second_tbl[DEPTH];
  logic [3:0]    cur_shift;
  logic [7:0]    cur_salt;
  verdict_t      pending_verdicts[$];
  logic [AW-1:0] granule_pool[$];
  int            errors = 0;
  int            cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [AW-1:0] granule_of(logic [AW-1:0] a);
    return a & ~((48'd1 << cur_shift) - 48'd1);
  endfunction

  function automatic logic [IDX_BITS-1:0] slot_index(logic [AW-1:0] g, bit second);
    logic [63:0] k;
    logic [63:0] p;
    k = {16'b0, g} >> cur_shift;
    k = k ^ (64'(cur_salt) * (second ? 64'(SALT_MUL_B) : 64'(SALT_MUL_A)));
    p = k * (second ? HASH_MUL_B : HASH_MUL_A);
    return p[63:64-IDX_BITS];
  endfunction

  // Apply one operation to the shadow tables and return its verdict.
  function automatic verdict_t apply_op(logic [1:0] kind, logic [AW-1:0] addr,
                                        logic [7:0] tag);
    verdict_t v;
    logic [AW-1:0] g;
    logic [IDX_BITS-1:0] ia, ib;
    entry_t hand, tmp;
    bit in_a, in_b, placed;
    v = '{tag_match: 1'b0, found: 1'b0, ok: 1'b1, spill_address: '0, spill_tag: '0};
    if (kind == KIND_NONE) return v;
    g = (kind == KIND_CHECK) ? granule_of(addr - 48'd4) : granule_of(addr);
    ia = slot_index(g, 1'b0);
    ib = slot_index(g, 1'b1);
    in_a = first_tbl[ia].used && first_tbl[ia].gaddr == g;
    in_b = !in_a && second_tbl[ib].used && second_tbl[ib].gaddr == g;
    v.found = in_a || in_b;
    case (kind)
      KIND_CHECK: begin
        if (in_a) v.tag_match = first_tbl[ia].tag == tag;
        else if (in_b) v.tag_match = second_tbl[ib].tag == tag;
        else v.tag_match = tag == 8'd0;
      end
      KIND_CLEAR: begin
        if (in_a) first_tbl[ia] = '0;
        else if (in_b) second_tbl[ib] = '0;
      end
      default: begin
        if (in_a) first_tbl[ia].tag = tag;
        else if (in_b) second_tbl[ib].tag = tag;
        else begin
          hand = '{used: 1'b1, gaddr: g, tag: tag};
          placed = 1'b0;
          for (int r = 0; r < KICK_LIMIT && !placed; r++) begin
            ia = slot_index(hand.gaddr, 1'b0);
            if (!first_tbl[ia].used) begin
              first_tbl[ia] = hand;
              placed = 1'b1;
            end else begin
              tmp = first_tbl[ia];
              first_tbl[ia] = hand;
              hand = tmp;
              ib = slot_index(hand.gaddr, 1'b1);
              if (!second_tbl[ib].used) begin
                second_tbl[ib] = hand;
                placed = 1'b1;
              end else begin
                tmp = second_tbl[ib];
                second_tbl[ib] = hand;
                hand = tmp;
              end
            end
          end
          if (!placed) begin
            v.ok = 1'b0;
            v.spill_address = hand.gaddr;
            v.spill_tag = hand.tag;
          end
        end
      end
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && strobe_o) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no operation outstanding");
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (tag_match_o !== want.tag_match) begin
          $error("tag_match: expected %0d, got %0d", want.tag_match, tag_match_o);
          errors++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          errors++;
        end
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok_o);
          errors++;
        end
        if (spill_address_o !== want.spill_address) begin
          $error("spill_address: expected %h, got %h", want.spill_address,
                 spill_address_o);
          errors++;
        end
        if (spill_tag_o !== want.spill_tag) begin
          $error("spill_tag: expected %h, got %h", want.spill_tag, spill_tag_o);
          errors++;
        end
      end
    end
  end

  // Hold start high across back-to-back beats; drop it only over a gap or a drain.
  task automatic issue_op(logic [1:0] kind, logic [AW-1:0] addr, logic [7:0] tag,
                          int gap = 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i <= kind;
    address_i <= addr;
    tag_i <= tag;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_verdicts.insert(pending_verdicts.size(), apply_op(kind, addr, tag));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    drain();
    repeat (10) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_SHIFT) cur_shift = (value[3:0] > SHIFT_MAX) ? SHIFT_MAX : value[3:0];
    else cur_salt = value[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic refill_pool(int n);
    granule_pool.delete();
    for (int i = 0; i < n; i++)
      granule_pool.insert(granule_pool.size(), granule_of(48'({$urandom, $urandom})));
  endtask

  // Find three granules sharing both slots, insert them, then check, clear and
  // set again: the third set spills if it stays in the shared granule.
  task automatic test_overflow();
    logic [AW-1:0] seen_a[bit [2*IDX_BITS-1:0]];
    logic [AW-1:0] seen_b[bit [2*IDX_BITS-1:0]];
    logic [AW-1:0] g;
    bit [2*IDX_BITS-1:0] key;
    for (int n = 0; n < 300000; n++) begin
      g = granule_of(48'({$urandom, $urandom}));
      key = {slot_index(g, 1'b0), slot_index(g, 1'b1)};
      if (!seen_a.exists(key)) seen_a[key] = g;
      else if (seen_a[key] == g) continue;
      else if (!seen_b.exists(key)) seen_b[key] = g;
      else if (seen_b[key] != g) begin
        issue_op(KIND_SET, seen_a[key], 8'($urandom), pick_gap());
        issue_op(KIND_SET, seen_b[key], 8'($urandom), pick_gap());
        issue_op(KIND_SET, g | 48'($urandom_range(0, 3)), 8'($urandom), pick_gap());
        issue_op(KIND_CHECK, seen_a[key] + 48'd4, 8'($urandom), pick_gap());
        issue_op(KIND_CLEAR, seen_b[key], 8'd0, pick_gap());
        issue_op(KIND_SET, g, 8'($urandom), pick_gap());
        return;
      end
    end
  endtask

  task automatic test_directed();
    issue_op(KIND_CHECK, 48'd0, 8'd0);
    issue_op(KIND_CHECK, 48'd3, 8'hff);
    issue_op(KIND_SET, 48'hffff_ffff_ffff, 8'hff);
    issue_op(KIND_CHECK, 48'd0, 8'hff);
    issue_op(KIND_CHECK, 48'd2, 8'hfe);
    issue_op(KIND_SET, 48'hffff_ffff_fff0, 8'h00);
    issue_op(KIND_CHECK, 48'd1, 8'd0);
    issue_op(KIND_SET, 48'h0000_0000_0013, 8'h5a, 2);
    issue_op(KIND_CHECK, 48'h0000_0000_0014, 8'h5a);
    issue_op(KIND_CHECK, 48'h0000_0000_0020, 8'h5a);
    issue_op(KIND_CHECK, 48'h0000_0000_0024, 8'h5b);
    issue_op(KIND_NONE, 48'h0000_0000_0010, 8'h5a);
    issue_op(KIND_NONE, 48'haaaa_5555_aaaa, 8'haa);
    issue_op(KIND_CLEAR, 48'h0000_0000_001f, 8'h00);
    issue_op(KIND_CLEAR, 48'h0000_0000_0010, 8'h00);
    issue_op(KIND_CHECK, 48'h0000_0000_0014, 8'h00);
    issue_op(KIND_CLEAR, 48'hffff_ffff_ffff, 8'hff, 5);
    issue_op(KIND_CHECK, 48'd0, 8'd0);
    issue_op(KIND_SET, 48'h5555_aaaa_5555, 8'h55);
    issue_op(KIND_CHECK, 48'h5555_aaaa_5559, 8'h55);
  endtask

  task automatic test_random(int n);
    logic [AW-1:0] base;
    logic [AW-1:0] off;
    int r;
    refill_pool(40);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      base = granule_pool[$urandom_range(0, granule_pool.size() - 1)];
      off = 48'({$urandom, $urandom}) & ((48'd1 << cur_shift) - 48'd1);
      if (r < 35) issue_op(KIND_SET, base | off, 8'($urandom), pick_gap());
      else if (r < 65) issue_op(KIND_CHECK, base + 48'd4 + off,
                                ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                                pick_gap());
      else if (r < 82) issue_op(KIND_CLEAR, base | off, 8'($urandom), pick_gap());
      else issue_op(2'($urandom), 48'({$urandom, $urandom}), 8'($urandom), pick_gap());
      if (i == n / 2 && $urandom_range(0, 1) == 1) drain();
    end
  endtask

  task automatic test_settings(logic [31:0] shift, logic [31:0] salt, int n);
    write_reg(ADDR_SHIFT, shift);
    write_reg(ADDR_SALT, salt);
    test_overflow();
    test_random(n);
  endtask

  initial begin
    cur_shift = SHIFT_RESET;
    cur_salt = 8'd0;
    for (int i = 0; i < DEPTH; i++) begin
      first_tbl[i] = '0;
      second_tbl[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_overflow();
    test_random(90);
    drain();
    test_settings(32'd0, 32'd255, 90);
    test_settings(32'd12, 32'd1, 90);
    test_settings(32'hffff_ffff, 32'h5a, 90);
    test_settings(32'd13, 32'd128, 80);
    test_settings(32'd7, 32'hffff_ff00, 80);
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cgts_pkg.sv
rtl/cgts_ram.sv
rtl/cgts_datapath.sv
rtl/cgts_ctrl.sv
rtl/cuckoo_granule_tag_store.sv
verif/testbench.sv
